### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the heap sort block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define HSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// pre at one edge implies post at the next
`define HSR_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### sv/hsr_pkg.sv
// ----------------------------------------------------------------------------
// hsr_pkg
// Constants, types and state codes of the heap sort records unit.
// ----------------------------------------------------------------------------
package hsr_pkg;

  localparam int MAX_RECORDS = 64;
  localparam int ADDR_W      = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int CHILD_W     = ADDR_W + 2;
  localparam int KEY_W       = 64;
  localparam int RATING_W    = 16;
  localparam int DIST_W      = 24;
  localparam int ID_W        = 6;
  localparam int MODE_W      = 2;

  localparam logic [CNT_W-1:0]  MAX_CNT     = CNT_W'(MAX_RECORDS);
  localparam logic [MODE_W-1:0] MODE_NAME   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RATING = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIST   = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } ram_req_t;

  typedef struct packed {
    logic [KEY_W-1:0] a;
    logic [KEY_W-1:0] b;
  } cmp_req_t;

  typedef struct packed {
    logic             load;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
    logic             eor;
  } emit_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_EX_RD,
    ST_EX_EMIT,
    ST_DN_RD,
    ST_DN_CL,
    ST_DN_CR
  } state_t;

endpackage

### sv/hsr_ram.sv
// ----------------------------------------------------------------------------
// hsr_ram
// Generic memory, one write port and two read ports with registered data.
// ----------------------------------------------------------------------------
module hsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### sv/hsr_cmp.sv
// ----------------------------------------------------------------------------
// hsr_cmp
// Shared key compare: true when key a ranks strictly before key b.
// ----------------------------------------------------------------------------
module hsr_cmp (
  input  logic [hsr_pkg::MODE_W-1:0] mode,
  input  hsr_pkg::cmp_req_t          req,
  output logic                       a_first
);

  always_comb begin
    case (mode)
      hsr_pkg::MODE_RATING: a_first = (req.a > req.b);
      default:              a_first = (req.a < req.b);
    endcase
  end

endmodule

### sv/hsr_seq.sv
// ----------------------------------------------------------------------------
// hsr_seq
// Sequencer: sift-up on load, root extraction and sift-down on the final item.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsr_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [hsr_pkg::KEY_W-1:0]    in_name_key,
  input  logic [hsr_pkg::RATING_W-1:0] in_rating,
  input  logic [hsr_pkg::DIST_W-1:0]   in_distance,
  input  logic [hsr_pkg::ID_W-1:0]     in_record_id,
  input  logic                         in_final_record,
  input  logic [hsr_pkg::MODE_W-1:0]   mode,
  output hsr_pkg::ram_req_t            ram_req,
  input  hsr_pkg::entry_t              rdata_a,
  input  hsr_pkg::entry_t              rdata_b,
  output hsr_pkg::cmp_req_t            cmp_req,
  input  logic                         a_first,
  input  logic                         out_free,
  output hsr_pkg::emit_t               emit
);

  hsr_pkg::state_t                  state_r, state_nxt;
  logic [hsr_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic [hsr_pkg::ADDR_W-1:0]       pos_r, pos_nxt;
  hsr_pkg::entry_t                  cur_r, cur_nxt;
  logic                             final_r, final_nxt;
  logic                             sel_l_r, sel_l_nxt;

  logic                             accept;
  logic                             room;
  logic [hsr_pkg::KEY_W-1:0]        in_key;
  logic [hsr_pkg::ADDR_W-1:0]       parent;
  logic [hsr_pkg::CHILD_W-1:0]      left_idx;
  logic [hsr_pkg::CHILD_W-1:0]      right_idx;
  logic                             left_ok;
  logic                             right_ok;
  logic                             take_r;

  assign accept    = in_valid && (state_r == hsr_pkg::ST_IDLE);
  assign room      = (count_r < hsr_pkg::MAX_CNT);
  assign parent    = hsr_pkg::ADDR_W'((pos_r - hsr_pkg::ADDR_W'(1)) >> 1);
  assign left_idx  = {1'b0, pos_r, 1'b1};
  assign right_idx = left_idx + hsr_pkg::CHILD_W'(1);
  assign left_ok   = (left_idx < hsr_pkg::CHILD_W'(count_r));
  assign right_ok  = (right_idx < hsr_pkg::CHILD_W'(count_r));
  assign take_r    = right_ok && a_first;

  always_comb begin
    case (mode)
      hsr_pkg::MODE_RATING: in_key = hsr_pkg::KEY_W'(in_rating);
      hsr_pkg::MODE_DIST:   in_key = hsr_pkg::KEY_W'(in_distance);
      default:              in_key = in_name_key;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hsr_pkg::ST_IDLE: begin
        if (accept) begin
          if (room) begin
            state_nxt = hsr_pkg::ST_UP_RD;
          end else if (in_final_record) begin
            state_nxt = hsr_pkg::ST_EX_RD;
          end
        end
      end
      hsr_pkg::ST_UP_RD: begin
        if (pos_r == '0) begin
          state_nxt = final_r ? hsr_pkg::ST_EX_RD : hsr_pkg::ST_IDLE;
        end else begin
          state_nxt = hsr_pkg::ST_UP_CMP;
        end
      end
      hsr_pkg::ST_UP_CMP: begin
        if (a_first) begin
          state_nxt = hsr_pkg::ST_UP_RD;
        end else begin
          state_nxt = final_r ? hsr_pkg::ST_EX_RD : hsr_pkg::ST_IDLE;
        end
      end
      hsr_pkg::ST_EX_RD: begin
        state_nxt = (count_r == '0) ? hsr_pkg::ST_IDLE : hsr_pkg::ST_EX_EMIT;
      end
      hsr_pkg::ST_EX_EMIT: begin
        if (out_free) begin
          state_nxt = hsr_pkg::ST_DN_RD;
        end
      end
      hsr_pkg::ST_DN_RD: begin
        state_nxt = left_ok ? hsr_pkg::ST_DN_CL : hsr_pkg::ST_EX_RD;
      end
      hsr_pkg::ST_DN_CL: begin
        state_nxt = hsr_pkg::ST_DN_CR;
      end
      hsr_pkg::ST_DN_CR: begin
        state_nxt = (take_r || sel_l_r) ? hsr_pkg::ST_DN_RD : hsr_pkg::ST_EX_RD;
      end
      default: begin
        state_nxt = hsr_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_stall        = (state_r != hsr_pkg::ST_IDLE);
    ram_req.we      = 1'b0;
    ram_req.waddr   = pos_r;
    ram_req.wdata   = cur_r;
    ram_req.raddr_a = parent;
    ram_req.raddr_b = parent;
    cmp_req.a       = cur_r.key;
    cmp_req.b       = rdata_a.key;
    emit.load       = 1'b0;
    emit.id         = rdata_a.id;
    emit.key        = rdata_a.key;
    emit.eor        = (count_r == hsr_pkg::CNT_W'(1));
    case (state_r)
      hsr_pkg::ST_UP_RD: begin
        ram_req.we = (pos_r == '0);
      end
      hsr_pkg::ST_UP_CMP: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = a_first ? rdata_a : cur_r;
      end
      hsr_pkg::ST_EX_RD, hsr_pkg::ST_EX_EMIT: begin
        ram_req.raddr_a = '0;
        ram_req.raddr_b = hsr_pkg::ADDR_W'(count_r - hsr_pkg::CNT_W'(1));
        emit.load       = (state_r == hsr_pkg::ST_EX_EMIT) && out_free;
      end
      hsr_pkg::ST_DN_RD: begin
        ram_req.we      = !left_ok;
        ram_req.raddr_a = hsr_pkg::ADDR_W'(left_idx);
        ram_req.raddr_b = hsr_pkg::ADDR_W'(right_idx);
      end
      hsr_pkg::ST_DN_CL: begin
        ram_req.raddr_a = hsr_pkg::ADDR_W'(left_idx);
        ram_req.raddr_b = hsr_pkg::ADDR_W'(right_idx);
        cmp_req.a       = rdata_a.key;
        cmp_req.b       = cur_r.key;
      end
      hsr_pkg::ST_DN_CR: begin
        ram_req.we      = 1'b1;
        ram_req.raddr_a = hsr_pkg::ADDR_W'(left_idx);
        ram_req.raddr_b = hsr_pkg::ADDR_W'(right_idx);
        cmp_req.a       = rdata_b.key;
        cmp_req.b       = sel_l_r ? rdata_a.key : cur_r.key;
        if (take_r) begin
          ram_req.wdata = rdata_b;
        end else if (sel_l_r) begin
          ram_req.wdata = rdata_a;
        end
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    count_nxt = count_r;
    pos_nxt   = pos_r;
    cur_nxt   = cur_r;
    final_nxt = final_r;
    sel_l_nxt = sel_l_r;
    case (state_r)
      hsr_pkg::ST_IDLE: begin
        if (accept) begin
          cur_nxt.key = in_key;
          cur_nxt.id  = in_record_id;
          pos_nxt     = hsr_pkg::ADDR_W'(count_r);
          final_nxt   = in_final_record;
        end
      end
      hsr_pkg::ST_UP_RD: begin
        if (pos_r == '0) begin
          count_nxt = count_r + hsr_pkg::CNT_W'(1);
        end
      end
      hsr_pkg::ST_UP_CMP: begin
        if (a_first) begin
          pos_nxt = parent;
        end else begin
          count_nxt = count_r + hsr_pkg::CNT_W'(1);
        end
      end
      hsr_pkg::ST_EX_EMIT: begin
        if (out_free) begin
          cur_nxt   = rdata_b;
          count_nxt = count_r - hsr_pkg::CNT_W'(1);
          pos_nxt   = '0;
        end
      end
      hsr_pkg::ST_DN_CL: begin
        sel_l_nxt = a_first;
      end
      hsr_pkg::ST_DN_CR: begin
        if (take_r) begin
          pos_nxt = hsr_pkg::ADDR_W'(right_idx);
        end else if (sel_l_r) begin
          pos_nxt = hsr_pkg::ADDR_W'(left_idx);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsr_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    cur_r   <= cur_nxt;
    final_r <= final_nxt;
    sel_l_r <= sel_l_nxt;
  end

  `HSR_ASSERT(a_count_bound, count_r <= hsr_pkg::MAX_CNT, "record count beyond store depth")
  `HSR_ASSERT(a_emit_nonempty, !emit.load || (count_r != '0), "emit from an empty heap")
  `HSR_ASSERT_NEXT(a_emit_then_sift, emit.load, state_r == hsr_pkg::ST_DN_RD, "no sift after emit")
  `HSR_ASSERT(a_up_not_root, (state_r != hsr_pkg::ST_UP_CMP) || (pos_r != '0), "sift-up past root")
  `HSR_ASSERT(a_dn_child_ok, (state_r != hsr_pkg::ST_DN_CL) || left_ok, "child read beyond heap")

endmodule

### sv/heap_sort_records_by_key_unit.sv
// ----------------------------------------------------------------------------
// heap_sort_records_by_key_unit
// Loads records into a binary heap by the selected key, then emits them sorted.
//
//   channel  signals                                   direction
//   in       in_valid / in_stall, record fields        item in
//   out      out_valid / out_stall, id, key, end flag  item out
//   cfg      cfg_valid / cfg_ready, cfg_sort_mode      register write
//
// Load: an accepted record climbs the heap, with a read step and a compare
//   step per level, and is written where it settles.
// Extract: per record the root is read and emitted and the last entry sifts
//   down, with a read and two compare steps per level, until the heap is empty.
// A held output register stalls extraction in its emit step only.
// Reset clears the record count and mode; the heap memory is not cleared.
// ----------------------------------------------------------------------------
module heap_sort_records_by_key_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [hsr_pkg::KEY_W-1:0]    in_name_key,
  input  logic [hsr_pkg::RATING_W-1:0] in_rating,
  input  logic [hsr_pkg::DIST_W-1:0]   in_distance,
  input  logic [hsr_pkg::ID_W-1:0]     in_record_id,
  input  logic                         in_final_record,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hsr_pkg::ID_W-1:0]     out_sorted_id,
  output logic [hsr_pkg::KEY_W-1:0]    out_sorted_key,
  output logic                         out_end_of_run,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [hsr_pkg::MODE_W-1:0]   cfg_sort_mode
);

  logic [hsr_pkg::MODE_W-1:0]  mode_r, mode_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [hsr_pkg::ID_W-1:0]    out_id_r;
  logic [hsr_pkg::KEY_W-1:0]   out_key_r;
  logic                        out_eor_r;

  hsr_pkg::ram_req_t           ram_req;
  hsr_pkg::cmp_req_t           cmp_req;
  hsr_pkg::emit_t              emit;
  logic [hsr_pkg::ENTRY_W-1:0] rdata_a;
  logic [hsr_pkg::ENTRY_W-1:0] rdata_b;
  logic                        a_first;
  logic                        out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign mode_nxt = (cfg_valid && cfg_ready) ? cfg_sort_mode : mode_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit.load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= hsr_pkg::MODE_NAME;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_id_r  <= emit.id;
      out_key_r <= emit.key;
      out_eor_r <= emit.eor;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sorted_id  = out_id_r;
  assign out_sorted_key = out_key_r;
  assign out_end_of_run = out_eor_r;

  hsr_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_name_key     (in_name_key),
    .in_rating       (in_rating),
    .in_distance     (in_distance),
    .in_record_id    (in_record_id),
    .in_final_record (in_final_record),
    .mode            (mode_r),
    .ram_req         (ram_req),
    .rdata_a         (hsr_pkg::entry_t'(rdata_a)),
    .rdata_b         (hsr_pkg::entry_t'(rdata_b)),
    .cmp_req         (cmp_req),
    .a_first         (a_first),
    .out_free        (out_free),
    .emit            (emit)
  );

  hsr_cmp u_cmp (
    .mode    (mode_r),
    .req     (cmp_req),
    .a_first (a_first)
  );

  hsr_ram #(
    .WIDTH (hsr_pkg::ENTRY_W),
    .DEPTH (hsr_pkg::MAX_RECORDS)
  ) u_heap_ram (
    .clk     (clk),
    .we      (ram_req.we),
    .waddr   (ram_req.waddr),
    .wdata   (ram_req.wdata),
    .raddr_a (ram_req.raddr_a),
    .raddr_b (ram_req.raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

endmodule
